>>> rtl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants of the picked color segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package pcs_pkg;

   localparam int MAX_DIM_DEF     = 2048;
   localparam int WINDOW_SIZE_DEF = 9;

   localparam int PIX_W     = 8;
   localparam int QBIT_W    = $clog2(PIX_W);
   localparam int PICK_W    = 11;
   localparam int DIM_CFG_W = 12;
   localparam int TOL_W     = 8;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_PICK_COL    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PICK_ROW    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HGT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL_FIRST   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL_SECOND  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL_THIRD   = 3'd6;

   localparam logic [DIM_CFG_W-1:0] FRAME_WIDTH_RST = 12'd640;
   localparam logic [DIM_CFG_W-1:0] FRAME_HGT_RST   = 12'd480;
   localparam logic [TOL_W-1:0]     TOL_FIRST_RST   = 8'd8;
   localparam logic [TOL_W-1:0]     TOL_SECOND_RST  = 8'd80;
   localparam logic [TOL_W-1:0]     TOL_THIRD_RST   = 8'd120;

   localparam logic [PIX_W-1:0] FILL_FIRST  = 8'd92;
   localparam logic [PIX_W-1:0] FILL_SECOND = 8'd37;
   localparam logic [PIX_W-1:0] FILL_THIRD  = 8'd201;

   localparam logic RES_KIND_MEAN  = 1'b0;
   localparam logic RES_KIND_PIXEL = 1'b1;

   typedef struct packed {
      logic [PIX_W-1:0] pix_first;
      logic [PIX_W-1:0] pix_second;
      logic [PIX_W-1:0] pix_third;
   } pcs_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] res_first;
      logic [PIX_W-1:0] res_second;
      logic [PIX_W-1:0] res_third;
      logic             res_kind;
      logic             end_of_frame;
   } pcs_rsp_type;

   typedef struct packed {
      logic              take_pix;
      logic              div_load;
      logic              div_step;
      logic [QBIT_W-1:0] div_bit;
      logic              report;
   } pcs_cmd_type;

   typedef struct packed {
      logic first_last;
      logic out_free;
   } pcs_status_type;

endpackage

`default_nettype wire

>>> rtl/pcs_ctrl.sv
// ----------------------------------------------------------------------------
// pcs_ctrl
// Sequencer: pixel intake, window mean division and mean report.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_ctrl import pcs_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  pcs_status_type      sts,
   output logic                req_stall,
   output pcs_cmd_type         cmd
);

   localparam logic [1:0] ST_RUN  = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_RPT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [QBIT_W-1:0] bit_ff, bit_in;

   always_comb begin
      state_in     = state_ff;
      bit_in       = bit_ff;
      req_stall    = 1'b1;
      cmd          = '0;
      cmd.div_bit  = bit_ff;
      unique case (state_ff)
         ST_RUN: begin
            req_stall    = !sts.out_free;
            cmd.take_pix = req_valid && sts.out_free;
            if (cmd.take_pix && sts.first_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            bit_in       = QBIT_W'(PIX_W - 1);
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (bit_ff == '0) begin
               state_in = ST_RPT;
            end else begin
               bit_in = bit_ff - QBIT_W'(1);
            end
         end
         ST_RPT: begin
            if (sts.out_free) begin
               cmd.report = 1'b1;
               state_in   = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         bit_ff   <= bit_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/pcs_datapath.sv
// ----------------------------------------------------------------------------
// pcs_datapath
// Registers, raster position, window sums, shift-subtract divider,
// tolerance compare and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_datapath import pcs_pkg::*; #(
   parameter int MAX_DIM     = MAX_DIM_DEF,
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  pcs_req_type                req_data,
   input  pcs_cmd_type                cmd,
   output pcs_status_type             sts,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output pcs_rsp_type                rsp_data
);

   localparam int POS_W = $clog2(MAX_DIM);
   localparam int CNT_W = $clog2(WINDOW_SIZE * WINDOW_SIZE + 1);
   localparam int SUM_W = PIX_W + CNT_W;
   localparam int HALF  = WINDOW_SIZE / 2;

   function automatic logic close_to(input logic [PIX_W-1:0] p,
                                     input logic [PIX_W-1:0] m,
                                     input logic [TOL_W-1:0] tol);
      logic [PIX_W-1:0] diff;
      diff = (p >= m) ? (p - m) : (m - p);
      return diff <= tol;
   endfunction

   // configuration
   logic [PICK_W-1:0]    pick_col_ff, pick_row_ff;
   logic [DIM_CFG_W-1:0] width_ff, height_ff;
   logic [TOL_W-1:0]     tol_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         pick_col_ff <= '0;
         pick_row_ff <= '0;
         width_ff    <= FRAME_WIDTH_RST;
         height_ff   <= FRAME_HGT_RST;
         tol_ff[0]   <= TOL_FIRST_RST;
         tol_ff[1]   <= TOL_SECOND_RST;
         tol_ff[2]   <= TOL_THIRD_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PICK_COL:    pick_col_ff <= csr_data[PICK_W-1:0];
            CSR_PICK_ROW:    pick_row_ff <= csr_data[PICK_W-1:0];
            CSR_FRAME_WIDTH: width_ff    <= csr_data[DIM_CFG_W-1:0];
            CSR_FRAME_HGT:   height_ff   <= csr_data[DIM_CFG_W-1:0];
            CSR_TOL_FIRST:   tol_ff[0]   <= csr_data[TOL_W-1:0];
            CSR_TOL_SECOND:  tol_ff[1]   <= csr_data[TOL_W-1:0];
            CSR_TOL_THIRD:   tol_ff[2]   <= csr_data[TOL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // effective frame size
   logic [DIM_CFG_W-1:0] w_eff, h_eff;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = DIM_CFG_W'(1);
      end else if (32'(width_ff) > 32'(MAX_DIM)) begin
         w_eff = DIM_CFG_W'(MAX_DIM);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = DIM_CFG_W'(1);
      end else if (32'(height_ff) > 32'(MAX_DIM)) begin
         h_eff = DIM_CFG_W'(MAX_DIM);
      end else begin
         h_eff = height_ff;
      end
   end

   // raster position and pass
   logic [POS_W-1:0] col_ff, col_in, row_ff, row_in;
   logic             pass_ff, pass_in;
   logic             row_end, last;
   logic signed [31:0] d_row, d_col;
   logic             in_win;

   always_comb begin
      row_end = (32'(col_ff) + 32'd1) >= 32'(w_eff);
      last    = row_end && ((32'(row_ff) + 32'd1) >= 32'(h_eff));
      d_row   = int'(row_ff) - int'(pick_row_ff) + HALF;
      d_col   = int'(col_ff) - int'(pick_col_ff) + HALF;
      in_win  = (d_row >= 0) && (d_row < WINDOW_SIZE) &&
                (d_col >= 0) && (d_col < WINDOW_SIZE);

      col_in  = col_ff;
      row_in  = row_ff;
      pass_in = pass_ff;
      if (cmd.take_pix) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
            if (pass_ff) begin
               pass_in = 1'b0;
            end
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + POS_W'(1);
         end else begin
            col_in = col_ff + POS_W'(1);
         end
      end
      if (cmd.report) begin
         pass_in = 1'b1;
      end
   end

   assign sts.first_last = last && !pass_ff;

   // window sums and divider
   logic [PIX_W-1:0] pix   [3];
   logic [SUM_W-1:0] sum_ff [3];
   logic [SUM_W-1:0] rem_ff [3];
   logic [PIX_W-1:0] quot_ff [3];
   logic [PIX_W-1:0] mean_ff [3];
   logic [PIX_W-1:0] mean_new [3];
   logic [CNT_W-1:0] count_ff;
   logic [SUM_W-1:0] divisor;

   assign pix[0]  = req_data.pix_first;
   assign pix[1]  = req_data.pix_second;
   assign pix[2]  = req_data.pix_third;
   assign divisor = SUM_W'(count_ff) << cmd.div_bit;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mean_new[c] = (count_ff == '0) ? '0 : quot_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int c = 0; c < 3; c++) begin
            sum_ff[c]  <= '0;
            mean_ff[c] <= '0;
         end
      end else if (cmd.report) begin
         count_ff <= '0;
         for (int c = 0; c < 3; c++) begin
            sum_ff[c]  <= '0;
            mean_ff[c] <= mean_new[c];
         end
      end else if (cmd.take_pix && !pass_ff && in_win) begin
         count_ff <= count_ff + CNT_W'(1);
         for (int c = 0; c < 3; c++) begin
            sum_ff[c] <= sum_ff[c] + SUM_W'(pix[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (cmd.div_load) begin
            rem_ff[c]  <= sum_ff[c];
            quot_ff[c] <= '0;
         end else if (cmd.div_step && (rem_ff[c] >= divisor)) begin
            rem_ff[c]               <= rem_ff[c] - divisor;
            quot_ff[c][cmd.div_bit] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         pass_ff <= 1'b0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         pass_ff <= pass_in;
      end
   end

   // output register
   logic        out_valid_ff, out_valid_in;
   pcs_rsp_type out_data_ff, out_data_in;
   logic        hit;

   always_comb begin
      hit = close_to(pix[0], mean_ff[0], tol_ff[0]) &&
            close_to(pix[1], mean_ff[1], tol_ff[1]) &&
            close_to(pix[2], mean_ff[2], tol_ff[2]);
      out_valid_in = out_valid_ff && rsp_stall;
      out_data_in  = out_data_ff;
      if (cmd.take_pix && pass_ff) begin
         out_valid_in             = 1'b1;
         out_data_in.res_first    = hit ? FILL_FIRST  : pix[0];
         out_data_in.res_second   = hit ? FILL_SECOND : pix[1];
         out_data_in.res_third    = hit ? FILL_THIRD  : pix[2];
         out_data_in.res_kind     = RES_KIND_PIXEL;
         out_data_in.end_of_frame = last;
      end else if (cmd.report) begin
         out_valid_in             = 1'b1;
         out_data_in.res_first    = mean_new[0];
         out_data_in.res_second   = mean_new[1];
         out_data_in.res_third    = mean_new[2];
         out_data_in.res_kind     = RES_KIND_MEAN;
         out_data_in.end_of_frame = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign sts.out_free = !out_valid_ff || !rsp_stall;
   assign rsp_valid    = out_valid_ff;
   assign rsp_data     = out_data_ff;

endmodule

`default_nettype wire

>>> rtl/picked_color_segmenter.sv
// ----------------------------------------------------------------------------
// picked_color_segmenter
// Two-pass color segmenter: window mean around a picked point, then
// replacement of pixels within tolerance of that mean by a fill color.
//
//   Port group | Direction | Beat
//   req_       | in        | one pixel, raster order
//   rsp_       | out       | mean report (end of first pass) or output pixel
//   csr_       | in        | register write, index per register list
//
// One pixel per cycle in both passes while the output register drains.
// After the last pixel of the first pass the input stalls for a divider
// load, 8 shift-subtract steps (3 channels in parallel) and a report step,
// which also waits for a free output register.
// Reset returns to the first pass at row 0, column 0 with cleared sums.
// A stalled result holds in the output register and stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module picked_color_segmenter import pcs_pkg::*; #(
   parameter int MAX_DIM     = MAX_DIM_DEF,
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  pcs_req_type                req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output pcs_rsp_type                rsp_data,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   pcs_cmd_type    cmd;
   pcs_status_type sts;

   pcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   pcs_datapath #(
      .MAX_DIM     (MAX_DIM),
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_stall_in_div: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_load || cmd.div_step) |-> req_stall)
      else $error("input taken while dividing");

   a_take_handshake: assert property (@(posedge clock) disable iff (reset)
      cmd.take_pix |-> (req_valid && !req_stall))
      else $error("pixel taken without handshake");

   a_report_out: assert property (@(posedge clock) disable iff (reset)
      cmd.report |=> (rsp_valid && rsp_data.res_kind == RES_KIND_MEAN &&
                      rsp_data.end_of_frame))
      else $error("mean report not presented");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.take_pix && (cmd.report || cmd.div_step || cmd.div_load)))
      else $error("pixel intake overlaps divider");

endmodule

`default_nettype wire
